@@ design/rfct_pkg.sv @@
// Shared types and codes for the raycast floor and ceiling texturer.
`timescale 1ns / 1ps
package rfct_pkg;

    localparam logic [1:0] OP_CEIL_WR  = 2'd0;
    localparam logic [1:0] OP_FLOOR_WR = 2'd1;
    localparam logic [1:0] OP_RENDER   = 2'd2;
    localparam logic [1:0] OP_UNUSED   = 2'd3;

    localparam logic [1:0] SIDE_NORTH = 2'd0;
    localparam logic [1:0] SIDE_SOUTH = 2'd1;
    localparam logic [1:0] SIDE_EAST  = 2'd2;
    localparam logic [1:0] SIDE_WEST  = 2'd3;

    localparam logic [1:0] DIRX_ZERO = 2'd0;
    localparam logic [1:0] DIRX_POS  = 2'd1;
    localparam logic [1:0] DIRX_NEG  = 2'd2;

    localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [1:0] REG_PLAYER_X      = 2'd2;
    localparam logic [1:0] REG_PLAYER_Y      = 2'd3;

    localparam logic [16:0] ONE_Q16 = 17'h10000;

    // widest texel index (two times the largest texture side exponent)
    localparam int TIDX_W = 16;
    // widest wall coordinate: largest map cell plus one, in Q.16
    localparam int WALL_W = 27;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [5:0]  map_x;
        logic [5:0]  map_y;
        logic [15:0] wall_frac;
        logic [1:0]  wall_side;
        logic [1:0]  dir_x_sign;
        logic        dir_y_positive;
        logic [15:0] perp_dist;
        logic [9:0]  screen_col;
        logic [9:0]  screen_row;
        logic [11:0] texel_index;
        logic [31:0] texel_value;
    } t_in_item;

    typedef struct packed {
        logic [19:0] pixel_address;
        logic [31:0] pixel_color;
        logic        is_floor;
        logic        last;
    } t_out_item;

    // work handed from the front pipeline to the texture side
    typedef struct packed {
        logic [1:0]        kind;
        logic [TIDX_W-1:0] tidx;
        logic [31:0]       tval;
        logic [19:0]       addr_c;
        logic [19:0]       addr_f;
    } t_job;

    // fields carried alongside the divider
    typedef struct packed {
        logic [1:0]        kind;
        logic [TIDX_W-1:0] tidx;
        logic [31:0]       tval;
        logic [WALL_W-1:0] wx;
        logic [WALL_W-1:0] wy;
        logic [19:0]       addr_c;
        logic [19:0]       addr_f;
    } t_carry;

endpackage

@@ design/rfct_front.sv @@
// Front pipeline: classify items, divide for row weight, blend, form texel index.
`timescale 1ns / 1ps
module rfct_front import rfct_pkg::*; #(
    parameter int TEX_BITS = 6,
    parameter int MAP_BITS = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in_item    i_item,
    input  logic [10:0] i_width,
    input  logic [10:0] i_height,
    input  logic [21:0] i_player_x,
    input  logic [21:0] i_player_y,
    output logic        o_job_valid,
    output t_job        o_job,
    input  logic        i_job_ready
);

    localparam int IW = 2 * TEX_BITS;
    localparam int NSTEP = 16;

    logic en;
    assign en = !o_job_valid || i_job_ready;
    assign o_ready = en;

    // stage 0: decode
    logic              bad_row;
    logic              n0_v;
    logic [WALL_W-1:0] n0_wx, n0_wy, cx, cy, fr;
    logic [MAP_BITS-1:0] mx, my;

    always_comb begin
        bad_row = ({1'b0, i_item.screen_row} >= i_height)
               || ({i_item.screen_row, 1'b0} <= i_height);
        n0_v = i_valid && ((i_item.opcode == OP_CEIL_WR) || (i_item.opcode == OP_FLOOR_WR)
               || ((i_item.opcode == OP_RENDER) && !bad_row));
        mx = MAP_BITS'(i_item.map_x);
        my = MAP_BITS'(i_item.map_y);
        cx = WALL_W'(mx) << 16;
        cy = WALL_W'(my) << 16;
        fr = WALL_W'(i_item.wall_frac);
        if (i_item.wall_side == SIDE_SOUTH && i_item.dir_x_sign == DIRX_POS) begin
            n0_wx = cx;
            n0_wy = cy + fr;
        end else if (i_item.wall_side == SIDE_NORTH && i_item.dir_x_sign == DIRX_NEG) begin
            n0_wx = cx + WALL_W'(ONE_Q16);
            n0_wy = cy + fr;
        end else if (i_item.wall_side == SIDE_EAST && i_item.dir_y_positive) begin
            n0_wx = cx + fr;
            n0_wy = cy;
        end else begin
            n0_wx = cx + fr;
            n0_wy = cy + WALL_W'(ONE_Q16);
        end
    end

    logic              r0_v;
    logic [1:0]        r0_kind;
    logic [TIDX_W-1:0] r0_tidx;
    logic [31:0]       r0_tval;
    logic [WALL_W-1:0] r0_wx, r0_wy;
    logic [9:0]        r0_ydiff, r0_y, r0_col;
    logic [10:0]       r0_hy;
    logic [15:0]       r0_perp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (en) begin
            r0_v <= n0_v;
        end
        if (en) begin
            r0_kind  <= i_item.opcode;
            r0_tidx  <= TIDX_W'(IW'(i_item.texel_index));
            r0_tval  <= i_item.texel_value;
            r0_wx    <= n0_wx;
            r0_wy    <= n0_wy;
            r0_ydiff <= 10'({1'b0, i_item.screen_row, 1'b0} - {1'b0, i_height});
            r0_y     <= i_item.screen_row;
            r0_hy    <= i_height - {1'b0, i_item.screen_row};
            r0_col   <= i_item.screen_col;
            r0_perp  <= i_item.perp_dist;
        end
    end

    // stage 1: products for denominator and both row addresses
    logic              r1_v;
    t_carry            r1_c;
    logic [25:0]       r1_den;
    logic [20:0]       r1_ay;
    logic [21:0]       r1_af;
    logic [9:0]        r1_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= r0_v;
        end
        if (en) begin
            r1_c.kind   <= r0_kind;
            r1_c.tidx   <= r0_tidx;
            r1_c.tval   <= r0_tval;
            r1_c.wx     <= r0_wx;
            r1_c.wy     <= r0_wy;
            r1_c.addr_c <= '0;
            r1_c.addr_f <= '0;
            r1_den      <= r0_ydiff * r0_perp;
            r1_ay       <= r0_y * i_width;
            r1_af       <= r0_hy * i_width;
            r1_col      <= r0_col;
        end
    end

    // stage 2: saturation test, addresses
    logic [34:0] num;
    logic        n2_sat;
    assign num = {i_height, 24'b0};
    assign n2_sat = (r1_den == '0) || ({7'b0, num} >= {r1_den, 16'b0});

    logic        r_dv   [0:NSTEP];
    t_carry      r_dc   [0:NSTEP];
    logic [25:0] r_dden [0:NSTEP];
    logic [34:0] r_drem [0:NSTEP];
    logic [15:0] r_dq   [0:NSTEP];
    logic        r_dsat [0:NSTEP];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (en) begin
            r_dv[0] <= r1_v;
        end
        if (en) begin
            r_dc[0].kind   <= r1_c.kind;
            r_dc[0].tidx   <= r1_c.tidx;
            r_dc[0].tval   <= r1_c.tval;
            r_dc[0].wx     <= r1_c.wx;
            r_dc[0].wy     <= r1_c.wy;
            r_dc[0].addr_c <= 20'(r1_ay + 21'(r1_col));
            r_dc[0].addr_f <= 20'(r1_af + 22'(r1_col));
            r_dden[0]      <= r1_den;
            r_drem[0]      <= num;
            r_dq[0]        <= '0;
            r_dsat[0]      <= n2_sat;
        end
    end

    // restoring division, one quotient bit per stage, most significant first
    for (genvar k = 0; k < NSTEP; k++) begin : g_div
        logic [41:0] dsh;
        logic        take;
        assign dsh  = 42'(r_dden[k]) << (NSTEP - 1 - k);
        assign take = {7'b0, r_drem[k]} >= dsh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k+1] <= 1'b0;
            end else if (en) begin
                r_dv[k+1] <= r_dv[k];
            end
            if (en) begin
                r_dc[k+1]   <= r_dc[k];
                r_dden[k+1] <= r_dden[k];
                r_dsat[k+1] <= r_dsat[k];
                r_drem[k+1] <= take ? 35'({7'b0, r_drem[k]} - dsh) : r_drem[k];
                r_dq[k+1]   <= r_dq[k] | (take ? (16'd1 << (NSTEP - 1 - k)) : 16'd0);
            end
        end
    end

    // blend products
    logic [16:0] w, wn;
    assign w  = r_dsat[NSTEP] ? ONE_Q16 : {1'b0, r_dq[NSTEP]};
    assign wn = ONE_Q16 - w;

    logic        rm_v;
    t_carry      rm_c;
    logic [43:0] rm_px, rm_py;
    logic [38:0] rm_qx, rm_qy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rm_v <= 1'b0;
        end else if (en) begin
            rm_v <= r_dv[NSTEP];
        end
        if (en) begin
            rm_c  <= r_dc[NSTEP];
            rm_px <= w * r_dc[NSTEP].wx;
            rm_py <= w * r_dc[NSTEP].wy;
            rm_qx <= wn * i_player_x;
            rm_qy <= wn * i_player_y;
        end
    end

    // sum and wrap to texture coordinates
    logic [31:0]       sx, sy;
    logic [IW-1:0]     tix;
    assign sx  = 32'(rm_px) + 32'(rm_qx);
    assign sy  = 32'(rm_py) + 32'(rm_qy);
    assign tix = {sy[31 -: TEX_BITS], sx[31 -: TEX_BITS]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_job_valid <= 1'b0;
        end else if (en) begin
            o_job_valid <= rm_v;
        end
        if (en) begin
            o_job.kind   <= rm_c.kind;
            o_job.tidx   <= (rm_c.kind == OP_RENDER) ? TIDX_W'(tix) : rm_c.tidx;
            o_job.tval   <= rm_c.tval;
            o_job.addr_c <= rm_c.addr_c;
            o_job.addr_f <= rm_c.addr_f;
        end
    end

endmodule

@@ design/rfct_queue.sv @@
// Small FIFO between the front pipeline and the texture side.
`timescale 1ns / 1ps
module rfct_queue #(
    parameter int W = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    output logic         o_valid,
    output logic [W-1:0] o_data,
    input  logic         i_pop
);

    localparam int AW = $clog2(DEPTH);

    logic [W-1:0]  r_mem [0:DEPTH-1];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

@@ design/rfct_back.sv @@
// Texture stores and pixel emission: ceiling result first, then floor.
`timescale 1ns / 1ps
module rfct_back import rfct_pkg::*; #(
    parameter int TEX_BITS = 6
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_job_valid,
    input  t_job      i_job,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    localparam int IW = 2 * TEX_BITS;
    localparam int DEPTH = 1 << IW;

    logic [31:0] r_ceil_mem  [0:DEPTH-1];
    logic [31:0] r_floor_mem [0:DEPTH-1];

    logic          r_cp, r_fp;
    logic          r_b_v, r_b_first, r_b_cp, r_b_fp;
    logic [19:0]   r_b_ac, r_b_af;
    logic [31:0]   r_c_rd, r_f_rd;
    logic [IW-1:0] idx;
    logic          show_ceil, fire, done, free, pop_render;

    assign idx       = i_job.tidx[IW-1:0];
    assign show_ceil = r_b_first && r_b_cp;
    assign o_valid   = r_b_v;
    assign fire      = r_b_v && i_ready;
    assign done      = fire && o_item.last;
    assign free      = !r_b_v || done;
    assign o_pop     = i_job_valid && ((i_job.kind != OP_RENDER) || free);
    assign pop_render = o_pop && (i_job.kind == OP_RENDER);

    always_comb begin
        if (show_ceil) begin
            o_item.pixel_address = r_b_ac;
            o_item.pixel_color   = r_c_rd;
            o_item.is_floor      = 1'b0;
            o_item.last          = !r_b_fp;
        end else begin
            o_item.pixel_address = r_b_af;
            o_item.pixel_color   = r_f_rd;
            o_item.is_floor      = 1'b1;
            o_item.last          = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_job.kind == OP_CEIL_WR) begin
            r_ceil_mem[idx] <= i_job.tval;
        end
        if (pop_render) begin
            r_c_rd <= r_ceil_mem[idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_job.kind == OP_FLOOR_WR) begin
            r_floor_mem[idx] <= i_job.tval;
        end
        if (pop_render) begin
            r_f_rd <= r_floor_mem[idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cp      <= 1'b0;
            r_fp      <= 1'b0;
            r_b_v     <= 1'b0;
            r_b_first <= 1'b0;
        end else begin
            if (o_pop && i_job.kind == OP_CEIL_WR) begin
                r_cp <= 1'b1;
            end
            if (o_pop && i_job.kind == OP_FLOOR_WR) begin
                r_fp <= 1'b1;
            end
            if (pop_render) begin
                // drop the row when neither texture is loaded
                r_b_v     <= r_cp || r_fp;
                r_b_first <= 1'b1;
            end else if (done) begin
                r_b_v <= 1'b0;
            end else if (fire) begin
                r_b_first <= 1'b0;
            end
        end
        if (pop_render) begin
            r_b_cp <= r_cp;
            r_b_fp <= r_fp;
            r_b_ac <= i_job.addr_c;
            r_b_af <= i_job.addr_f;
        end
    end

endmodule

@@ design/raycast_floor_ceiling_texturer.sv @@
// Top level of the raycast floor and ceiling texturer.
// Takes one item per cycle unless held back by a full queue. A row item runs
// through the front pipeline (decode, products, a 16-stage restoring divider
// for the row weight, blend products, texel index), waits in a four-entry
// queue, then reads both texture memories together and emits its ceiling
// pixel and then its floor pixel, so a row with both textures loaded
// occupies the output for two results. Texel writes take the same path, so
// they land in order with the rows around them. A texture never written
// gives no pixel for a row, and a row is dropped when neither is written.
`timescale 1ns / 1ps
module raycast_floor_ceiling_texturer import rfct_pkg::*; #(
    parameter int TEX_BITS = 6,
    parameter int MAP_BITS = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in_item    i_item,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_item   o_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [21:0] i_cfg_data
);

    logic [10:0] r_width, r_height;
    logic [21:0] r_player_x, r_player_y;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= 11'd640;
            r_height   <= 11'd480;
            r_player_x <= '0;
            r_player_y <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SCREEN_WIDTH:  r_width    <= i_cfg_data[10:0];
                REG_SCREEN_HEIGHT: r_height   <= i_cfg_data[10:0];
                REG_PLAYER_X:      r_player_x <= i_cfg_data;
                REG_PLAYER_Y:      r_player_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic job_valid, q_full, q_valid, q_pop;
    t_job job, q_job;

    rfct_front #(.TEX_BITS(TEX_BITS), .MAP_BITS(MAP_BITS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_item     (i_item),
        .i_width    (r_width),
        .i_height   (r_height),
        .i_player_x (r_player_x),
        .i_player_y (r_player_y),
        .o_job_valid(job_valid),
        .o_job      (job),
        .i_job_ready(!q_full)
    );

    rfct_queue #(.W($bits(t_job)), .DEPTH(4)) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (job_valid && !q_full),
        .i_data (job),
        .o_full (q_full),
        .o_valid(q_valid),
        .o_data (q_job),
        .i_pop  (q_pop)
    );

    rfct_back #(.TEX_BITS(TEX_BITS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job_valid(q_valid),
        .i_job      (q_job),
        .o_pop      (q_pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_item     (o_item)
    );

endmodule

@@ design/rfct_checker.sv @@
// Port-level checks for the texturer, bound to the top level.
`timescale 1ns / 1ps
module rfct_checker import rfct_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_valid,
    input logic      i_ready,
    input t_out_item o_item
);

    // a result that is not last is always a ceiling pixel
    a_first_is_ceil: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_item.last) |-> !o_item.is_floor)
        else $error("non-final result is not a ceiling pixel");

    // a taken ceiling pixel that is not last is followed by its floor pixel
    a_floor_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_item.last) |=> (o_valid && o_item.is_floor))
        else $error("floor pixel does not follow ceiling pixel");

    // nothing is shown in the cycle after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result shown right after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_item)))
        else $error("stalled result changed");

endmodule

bind raycast_floor_ceiling_texturer rfct_checker u_rfct_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .o_valid(o_valid),
    .i_ready(i_ready),
    .o_item (o_item)
);
